// ===== hw/rtl/obm_pkg.sv =====
// Shared types and codes for the order book level matcher.
// No dependencies; the top level, obm_seq and the testbench import this package.
`default_nettype none

package obm_pkg;

  // Request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_MATCH = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_PUBLISHED = 3'd0;
  localparam logic [2:0] KIND_PARTIAL   = 3'd1;
  localparam logic [2:0] KIND_FINAL     = 3'd2;
  localparam logic [2:0] KIND_REMAIN    = 3'd3;
  localparam logic [2:0] KIND_FULL      = 3'd4;

  // One result item as produced by the sequencer
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  market;
    logic [2:0]  symbol;
    logic        side;
    logic [31:0] price;
    logic [31:0] fill_qty;
    logic [31:0] leave_qty;
    logic [31:0] order_tag;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/order_book_level_matcher_unit.sv =====
// Top level of the order book level matcher: sequencer, two memories, result register.
// Depends on obm_pkg, obm_count_mem, obm_level_mem and obm_seq.
//
//   channel   handshake               payload
//   request   start / busy            req_type market symbol side price quantity order_tag
//   result    result_valid (strobe)   result_kind out_market out_symbol out_side out_price
//                                     fill_qty leave_qty out_order_tag last
//
// A request is taken when start is high and busy is low; busy stays high until its
// last result has been decided. A load gives its one result from S_CNT, through the result register.
// An order on a non-empty book walks its levels one per cycle through the level memory's read port
// (next level prefetched while the current one is written back); its results come from S_WALK
// and S_REM through the result register.
// Each result shows for one cycle on result_valid; the receiver cannot stall it.
// rst is synchronous; it empties every book at once, no clearing pass.
`default_nettype none

module order_book_level_matcher_unit #(
  parameter int MARKETS = 3,
  parameter int SYMBOLS = 8,
  parameter int LEVELS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [1:0]  market,
  input  logic [2:0]  symbol,
  input  logic        side,
  input  logic [31:0] price,
  input  logic [31:0] quantity,
  input  logic [31:0] order_tag,
  output logic        result_valid,
  output logic [2:0]  result_kind,
  output logic [1:0]  out_market,
  output logic [2:0]  out_symbol,
  output logic        out_side,
  output logic [31:0] out_price,
  output logic [31:0] fill_qty,
  output logic [31:0] leave_qty,
  output logic [31:0] out_order_tag,
  output logic        last
);

  import obm_pkg::*;

  localparam int BOOKS  = MARKETS * SYMBOLS * 2;
  localparam int DEPTH  = BOOKS * LEVELS;
  localparam int BOOK_W = $clog2(BOOKS);
  localparam int CNT_W  = $clog2(LEVELS + 1);
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              cnt_rd_en;
  logic [BOOK_W-1:0] cnt_rd_addr;
  logic [CNT_W-1:0]  cnt_rd_data;
  logic              cnt_wr_en;
  logic [BOOK_W-1:0] cnt_wr_addr;
  logic [CNT_W-1:0]  cnt_wr_data;
  logic              lvl_rd_en;
  logic [ADDR_W-1:0] lvl_rd_addr;
  logic [31:0]       lvl_rd_price;
  logic [31:0]       lvl_rd_qty;
  logic              lvl_wr_en;
  logic [ADDR_W-1:0] lvl_wr_addr;
  logic [31:0]       lvl_wr_price;
  logic [31:0]       lvl_wr_qty;
  logic              emit;
  res_t              res;

  obm_seq #(
    .MARKETS (MARKETS),
    .SYMBOLS (SYMBOLS),
    .LEVELS  (LEVELS),
    .BOOK_W  (BOOK_W),
    .CNT_W   (CNT_W),
    .LVL_W   (LVL_W),
    .ADDR_W  (ADDR_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .market       (market),
    .symbol       (symbol),
    .side         (side),
    .price        (price),
    .quantity     (quantity),
    .order_tag    (order_tag),
    .cnt_rd_en    (cnt_rd_en),
    .cnt_rd_addr  (cnt_rd_addr),
    .cnt_rd_data  (cnt_rd_data),
    .cnt_wr_en    (cnt_wr_en),
    .cnt_wr_addr  (cnt_wr_addr),
    .cnt_wr_data  (cnt_wr_data),
    .lvl_rd_en    (lvl_rd_en),
    .lvl_rd_addr  (lvl_rd_addr),
    .lvl_rd_price (lvl_rd_price),
    .lvl_rd_qty   (lvl_rd_qty),
    .lvl_wr_en    (lvl_wr_en),
    .lvl_wr_addr  (lvl_wr_addr),
    .lvl_wr_price (lvl_wr_price),
    .lvl_wr_qty   (lvl_wr_qty),
    .emit         (emit),
    .res          (res)
  );

  obm_count_mem #(
    .BOOKS  (BOOKS),
    .BOOK_W (BOOK_W),
    .CNT_W  (CNT_W)
  ) u_count_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd_data),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data)
  );

  obm_level_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_level_mem (
    .clk      (clk),
    .rd_en    (lvl_rd_en),
    .rd_addr  (lvl_rd_addr),
    .rd_price (lvl_rd_price),
    .rd_qty   (lvl_rd_qty),
    .wr_en    (lvl_wr_en),
    .wr_addr  (lvl_wr_addr),
    .wr_price (lvl_wr_price),
    .wr_qty   (lvl_wr_qty)
  );

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (emit) begin
      result_kind   <= res.kind;
      out_market    <= res.market;
      out_symbol    <= res.symbol;
      out_side      <= res.side;
      out_price     <= res.price;
      fill_qty      <= res.fill_qty;
      leave_qty     <= res.leave_qty;
      out_order_tag <= res.order_tag;
      last          <= res.last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/obm_count_mem.sv =====
// Per-book level count memory with registered read.
// Valid bits per book make unwritten counts read as zero after reset. No package use.
`default_nettype none

module obm_count_mem #(
  parameter int BOOKS  = 48,
  parameter int BOOK_W = 6,
  parameter int CNT_W  = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [BOOK_W-1:0] rd_addr,
  output logic [CNT_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [BOOK_W-1:0] wr_addr,
  input  logic [CNT_W-1:0]  wr_data
);

  logic [CNT_W-1:0] mem [BOOKS];
  logic [BOOKS-1:0] valid;
  logic [CNT_W-1:0] rd_word;
  logic             rd_valid;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark books written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  // Unwritten books hold no levels
  assign rd_data = rd_valid ? rd_word : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/obm_level_mem.sv =====
// Level store: price and quantity of every level of every book.
// Single write port, single registered read port. No package use.
`default_nettype none

module obm_level_mem #(
  parameter int DEPTH  = 1536,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]       rd_price,
  output logic [31:0]       rd_qty,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_price,
  input  logic [31:0]       wr_qty
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_word;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_price, wr_qty};
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_price = rd_word[63:32];
  assign rd_qty   = rd_word[31:0];

endmodule

`default_nettype wire

// ===== hw/rtl/obm_seq.sv =====
// Request sequencer: count lookup, level append, and the level walk of an order.
// Depends on obm_pkg; drives obm_count_mem and obm_level_mem.
`default_nettype none

module obm_seq #(
  parameter int MARKETS = 3,
  parameter int SYMBOLS = 8,
  parameter int LEVELS  = 32,
  parameter int BOOK_W  = 6,
  parameter int CNT_W   = 6,
  parameter int LVL_W   = 5,
  parameter int ADDR_W  = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [1:0]        market,
  input  logic [2:0]        symbol,
  input  logic              side,
  input  logic [31:0]       price,
  input  logic [31:0]       quantity,
  input  logic [31:0]       order_tag,
  output logic              cnt_rd_en,
  output logic [BOOK_W-1:0] cnt_rd_addr,
  input  logic [CNT_W-1:0]  cnt_rd_data,
  output logic              cnt_wr_en,
  output logic [BOOK_W-1:0] cnt_wr_addr,
  output logic [CNT_W-1:0]  cnt_wr_data,
  output logic              lvl_rd_en,
  output logic [ADDR_W-1:0] lvl_rd_addr,
  input  logic [31:0]       lvl_rd_price,
  input  logic [31:0]       lvl_rd_qty,
  output logic              lvl_wr_en,
  output logic [ADDR_W-1:0] lvl_wr_addr,
  output logic [31:0]       lvl_wr_price,
  output logic [31:0]       lvl_wr_qty,
  output logic              emit,
  output obm_pkg::res_t     res
);

  import obm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CNT  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_REM  = 2'd3;

  logic [1:0]        state, state_next;
  logic              accept;
  logic              present_in;
  logic [15:0]       book_wide;
  logic [BOOK_W-1:0] book_in;

  logic              rq_type;
  logic [1:0]        rq_mkt;
  logic [2:0]        rq_sym;
  logic              rq_side;
  logic [31:0]       rq_price;
  logic [31:0]       rq_id;
  logic              present;
  logic [BOOK_W-1:0] book;
  logic [ADDR_W-1:0] base;
  logic [31:0]       remain, remain_next;
  logic [LVL_W-1:0]  idx, idx_next, idx_inc;
  logic [CNT_W-1:0]  cnt_lvls, cnt_lvls_next;
  logic [CNT_W-1:0]  cnt_cur;
  logic              last_lvl;
  logic              takes;

  // Decode the addressed book from the request ports
  assign accept     = start && !busy;
  assign present_in = (int'(market) < MARKETS) && (int'(symbol) < SYMBOLS);
  assign book_wide  = (16'(market) * 16'(SYMBOLS) + 16'(symbol)) * 16'd2 + 16'(side);
  assign book_in    = present_in ? book_wide[BOOK_W-1:0] : '0;
  assign busy       = (state != S_IDLE);

  // Walk helpers
  assign cnt_cur  = present ? cnt_rd_data : '0;
  assign idx_inc  = idx + LVL_W'(1);
  assign last_lvl = ((CNT_W'(idx) + CNT_W'(1)) == cnt_lvls);
  assign takes    = rq_side ? (lvl_rd_price >= rq_price) : (lvl_rd_price <= rq_price);

  // Next state, memory accesses and result
  always_comb begin
    state_next    = state;
    remain_next   = remain;
    idx_next      = idx;
    cnt_lvls_next = cnt_lvls;

    cnt_rd_en   = accept;
    cnt_rd_addr = book_in;
    cnt_wr_en   = 1'b0;
    cnt_wr_addr = book;
    cnt_wr_data = cnt_cur + CNT_W'(1);

    lvl_rd_en    = 1'b0;
    lvl_rd_addr  = base;
    lvl_wr_en    = 1'b0;
    lvl_wr_addr  = base + ADDR_W'(idx);
    lvl_wr_price = rq_price;
    lvl_wr_qty   = remain;

    emit          = 1'b0;
    res.kind      = KIND_REMAIN;
    res.market    = rq_mkt;
    res.symbol    = rq_sym;
    res.side      = rq_side;
    res.price     = rq_price;
    res.fill_qty  = remain;
    res.leave_qty = remain;
    res.order_tag = rq_id;
    res.last      = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CNT;
        end
      end
      S_CNT: begin
        if (rq_type == REQ_LOAD) begin
          // Append the level, or refuse it
          emit          = 1'b1;
          res.leave_qty = '0;
          res.order_tag = '0;
          if (!present || cnt_cur >= CNT_W'(LEVELS)) begin
            res.kind = KIND_FULL;
          end else begin
            res.kind    = KIND_PUBLISHED;
            lvl_wr_en   = 1'b1;
            lvl_wr_addr = base + ADDR_W'(cnt_cur);
            cnt_wr_en   = 1'b1;
          end
          state_next = S_IDLE;
        end else if (remain == '0) begin
          // Drop empty orders silently
          state_next = S_IDLE;
        end else if (cnt_cur == '0) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          lvl_rd_en     = 1'b1;
          idx_next      = '0;
          cnt_lvls_next = cnt_cur;
          state_next    = S_WALK;
        end
      end
      S_WALK: begin
        // Prefetch the next level while this one is settled
        if (!last_lvl) begin
          lvl_rd_en   = 1'b1;
          lvl_rd_addr = base + ADDR_W'(idx_inc);
          idx_next    = idx_inc;
        end
        if (takes && lvl_rd_qty != '0) begin
          emit         = 1'b1;
          lvl_wr_en    = 1'b1;
          lvl_wr_price = lvl_rd_price;
          res.price    = lvl_rd_price;
          if (remain > lvl_rd_qty) begin
            lvl_wr_qty    = '0;
            remain_next   = remain - lvl_rd_qty;
            res.kind      = KIND_PARTIAL;
            res.fill_qty  = lvl_rd_qty;
            res.leave_qty = remain - lvl_rd_qty;
            res.last      = 1'b0;
            if (last_lvl) begin
              state_next = S_REM;
            end
          end else begin
            lvl_rd_en     = 1'b0;
            lvl_wr_qty    = lvl_rd_qty - remain;
            res.kind      = KIND_FINAL;
            res.leave_qty = '0;
            state_next    = S_IDLE;
          end
        end else if (last_lvl) begin
          state_next = S_REM;
        end
      end
      S_REM: begin
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request and walk position
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    cnt_lvls <= cnt_lvls_next;
    if (accept) begin
      rq_type  <= req_type;
      rq_mkt   <= market;
      rq_sym   <= symbol;
      rq_side  <= side;
      rq_price <= price;
      rq_id    <= order_tag;
      present  <= present_in;
      book     <= book_in;
      base     <= ADDR_W'(book_in) * ADDR_W'(LEVELS);
      remain   <= quantity;
    end else begin
      remain <= remain_next;
    end
  end

`ifndef SYNTHESIS
  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (rst)
    (lvl_wr_en && lvl_rd_en) |-> (lvl_wr_addr != lvl_rd_addr))
    else $error("level read and write hit the same entry");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (emit && res.last) |=> (state == S_IDLE))
    else $error("sequencer still busy after the last result");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (CNT_W'(idx) < cnt_lvls))
    else $error("walk index beyond the level count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_wr_en |-> (cnt_wr_data <= CNT_W'(LEVELS) && cnt_wr_data != '0))
    else $error("level count written out of range");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !emit)
    else $error("result produced while idle");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for order_book_level_matcher_unit: drives load and match requests through
// start/busy and checks every strobed result against an in-bench book predictor.
// Depends on obm_pkg and the order_book_level_matcher_unit RTL.
`timescale 1ns / 100ps

import obm_pkg::*;

// Mirror of every book: predicts the reports each accepted request causes.
class match_scoreboard;
  localparam int MARKETS = 3;
  localparam int SYMBOLS = 8;
  localparam int LEVELS  = 32;
  localparam int NBOOKS  = MARKETS * SYMBOLS * 2;

  bit [31:0]   lvl_price [NBOOKS][LEVELS];
  bit [31:0]   lvl_qty   [NBOOKS][LEVELS];
  int unsigned lvl_count [NBOOKS];
  res_t        due_reports[$];
  int          errors;

  function int pending();
    return due_reports.size();
  endfunction

  // Apply one accepted request to the books and queue the reports it causes.
  function void note_request(logic rq, logic [1:0] mkt, logic [2:0] sym, logic sd,
                             logic [31:0] pr, logic [31:0] qty, logic [31:0] id);
    res_t        r;
    int          bk;
    int          i;
    bit          present;
    logic [31:0] remain;
    logic [31:0] lq;
    bit          takes;
    present      = (mkt < MARKETS) && (sym < SYMBOLS);
    bk           = present ? (int'(mkt) * SYMBOLS + int'(sym)) * 2 + int'(sd) : 0;
    r.market     = mkt;
    r.symbol     = sym;
    r.side       = sd;
    r.order_tag  = '0;
    r.leave_qty  = '0;
    r.last       = 1'b1;

    // Load: append and publish, or refuse when the book is absent or full
    if (rq == REQ_LOAD) begin
      r.price    = pr;
      r.fill_qty = qty;
      if (!present || lvl_count[bk] >= LEVELS) begin
        r.kind = KIND_FULL;
      end else begin
        lvl_price[bk][lvl_count[bk]] = pr;
        lvl_qty[bk][lvl_count[bk]]   = qty;
        lvl_count[bk]++;
        r.kind = KIND_PUBLISHED;
      end
      due_reports.push_back(r);
      return;
    end

    // Zero quantity order: nothing happens
    if (qty == 0) return;

    // Walk levels in load order; skip levels out of price or already exhausted
    remain      = qty;
    r.order_tag = id;
    if (present) begin
      for (i = 0; i < int'(lvl_count[bk]); i++) begin
        lq    = lvl_qty[bk][i];
        takes = (sd == 1'b0) ? (lvl_price[bk][i] <= pr) : (lvl_price[bk][i] >= pr);
        if (!takes || lq == 0) continue;
        r.price = lvl_price[bk][i];
        if (remain > lq) begin
          remain          = remain - lq;
          lvl_qty[bk][i]  = '0;
          r.kind          = KIND_PARTIAL;
          r.fill_qty      = lq;
          r.leave_qty     = remain;
          r.last          = 1'b0;
          due_reports.push_back(r);
        end else begin
          lvl_qty[bk][i]  = lq - remain;
          r.kind          = KIND_FINAL;
          r.fill_qty      = remain;
          r.leave_qty     = '0;
          r.last          = 1'b1;
          due_reports.push_back(r);
          return;
        end
      end
    end
    r.kind      = KIND_REMAIN;
    r.price     = pr;
    r.fill_qty  = remain;
    r.leave_qty = remain;
    r.last      = 1'b1;
    due_reports.push_back(r);
  endfunction

  function void log_error(string what, res_t want, res_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s", $realtime, what);
      $display("  expected kind %0d mkt %0d sym %0d side %0d px %h fill %h leave %h id %h last %0d",
               want.kind, want.market, want.symbol, want.side, want.price, want.fill_qty,
               want.leave_qty, want.order_tag, want.last);
      $display("  actual   kind %0d mkt %0d sym %0d side %0d px %h fill %h leave %h id %h last %0d",
               got.kind, got.market, got.symbol, got.side, got.price, got.fill_qty,
               got.leave_qty, got.order_tag, got.last);
    end
  endfunction

  // Compare one strobed report with the oldest prediction.
  function void check_report(res_t got);
    res_t want;
    bit   bad;
    if (due_reports.size() == 0) begin
      want = '0;
      log_error("report with nothing expected", want, got);
      return;
    end
    want = due_reports.pop_front();
    bad  = (got.kind !== want.kind) || (got.market !== want.market) ||
           (got.symbol !== want.symbol) || (got.side !== want.side) ||
           (got.price !== want.price) || (got.fill_qty !== want.fill_qty) ||
           (got.leave_qty !== want.leave_qty) || (got.order_tag !== want.order_tag) ||
           (got.last !== want.last);
    if (bad) log_error("report mismatch", want, got);
  endfunction
endclass

module tb;
  localparam int MARKETS    = 3;
  localparam int SYMBOLS    = 8;
  localparam int LEVELS     = 32;
  localparam int RAND_ITEMS = 250;
  localparam int QUIET_TAIL = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        req_type;
  logic [1:0]  market;
  logic [2:0]  symbol;
  logic        side;
  logic [31:0] price;
  logic [31:0] quantity;
  logic [31:0] order_tag;
  logic        result_valid;
  logic [2:0]  result_kind;
  logic [1:0]  out_market;
  logic [2:0]  out_symbol;
  logic        out_side;
  logic [31:0] out_price;
  logic [31:0] fill_qty;
  logic [31:0] leave_qty;
  logic [31:0] out_order_tag;
  logic        last;

  match_scoreboard sb = new;
  int unsigned     n_items;
  bit              gaps_on;
  bit              quiet;

  order_book_level_matcher_unit #(
    .MARKETS(MARKETS),
    .SYMBOLS(SYMBOLS),
    .LEVELS (LEVELS)
  ) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .market(market), .symbol(symbol), .side(side),
    .price(price), .quantity(quantity), .order_tag(order_tag),
    .result_valid(result_valid), .result_kind(result_kind), .out_market(out_market),
    .out_symbol(out_symbol), .out_side(out_side), .out_price(out_price),
    .fill_qty(fill_qty), .leave_qty(leave_qty), .out_order_tag(out_order_tag),
    .last(last)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample every strobed report at the rising edge
  always @(posedge clk) begin
    res_t got;
    if (!rst && result_valid === 1'b1) begin
      got.kind      = result_kind;
      got.market    = out_market;
      got.symbol    = out_symbol;
      got.side      = out_side;
      got.price     = out_price;
      got.fill_qty  = fill_qty;
      got.leave_qty = leave_qty;
      got.order_tag = out_order_tag;
      got.last      = last;
      sb.check_report(got);
    end
  end

  // Drive one item from a falling edge, hold it until taken, return at a falling edge.
  task automatic send_request(logic rq, logic [1:0] mkt, logic [2:0] sym, logic sd,
                              logic [31:0] pr, logic [31:0] qty, logic [31:0] id);
    if (!quiet && gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    start     <= 1'b1;
    req_type  <= rq;
    market    <= mkt;
    symbol    <= sym;
    side      <= sd;
    price     <= pr;
    quantity  <= qty;
    order_tag <= id;
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    sb.note_request(rq, mkt, sym, sd, pr, qty, id);
    n_items++;
    @(negedge clk);
  endtask

  // Mostly small quantities, now and then zero or full range
  function automatic logic [31:0] pick_qty();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel < 3) return $urandom;
    return $urandom_range(1, 60);
  endfunction

  initial begin
    int unsigned pick;
    int unsigned seq_no;
    int unsigned nlev;
    int unsigned j;
    logic [1:0]  mkt;
    logic [2:0]  sym;
    logic        sd;
    logic [31:0] base;
    logic [31:0] qty;

    rst       = 1'b1;
    start     = 1'b0;
    req_type  = REQ_LOAD;
    market    = '0;
    symbol    = '0;
    side      = 1'b0;
    price     = '0;
    quantity  = '0;
    order_tag = '0;
    n_items   = 0;
    gaps_on   = 1'b0;
    quiet     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: side 0 book, zero quantity load, exhausted levels, partial/final/remainder
    send_request(REQ_LOAD,  2'd0, 3'd0, 1'b0, 32'd100, 32'd10, 32'h1234_5678);
    send_request(REQ_LOAD,  2'd0, 3'd0, 1'b0, 32'd90,  32'd0,  32'hFFFF_FFFF);
    send_request(REQ_LOAD,  2'd0, 3'd0, 1'b0, 32'd110, 32'd20, 32'd0);
    send_request(REQ_LOAD,  2'd0, 3'd0, 1'b0, 32'd95,  32'd5,  32'd7);
    send_request(REQ_MATCH, 2'd0, 3'd0, 1'b0, 32'd100, 32'd0,  32'd1);
    send_request(REQ_MATCH, 2'd0, 3'd0, 1'b0, 32'd100, 32'd12, 32'd2);
    send_request(REQ_MATCH, 2'd0, 3'd0, 1'b0, 32'd100, 32'd50, 32'hFFFF_FFFF);
    send_request(REQ_MATCH, 2'd0, 3'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_request(REQ_LOAD,  2'd0, 3'd0, 1'b0, 32'd0,   32'd3,  32'd9);
    send_request(REQ_MATCH, 2'd0, 3'd0, 1'b0, 32'd0,   32'd3,  32'hA5A5_A5A5);
    send_request(REQ_MATCH, 2'd0, 3'd0, 1'b0, 32'd0,   32'd1,  32'h5A5A_5A5A);
    // Directed: side 1 book at the top of the index ranges, extreme prices
    send_request(REQ_LOAD,  2'd2, 3'd7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3);
    send_request(REQ_LOAD,  2'd2, 3'd7, 1'b1, 32'd0,   32'd1,  32'd4);
    send_request(REQ_LOAD,  2'd2, 3'd7, 1'b1, 32'd500, 32'd7,  32'd5);
    send_request(REQ_MATCH, 2'd2, 3'd7, 1'b1, 32'd500, 32'd7,  32'd6);
    send_request(REQ_MATCH, 2'd2, 3'd7, 1'b1, 32'd0,   32'hFFFF_FFFF, 32'd8);
    // Directed: absent book
    send_request(REQ_LOAD,  2'd3, 3'd5, 1'b1, 32'd123, 32'd45, 32'd11);
    send_request(REQ_MATCH, 2'd3, 3'd0, 1'b0, 32'd77,  32'd9,  32'd12);
    send_request(REQ_MATCH, 2'd3, 3'd7, 1'b1, 32'd77,  32'd0,  32'd13);

    // Random sequences
    seq_no = 0;
    while (n_items < 19 + RAND_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      quiet   = (n_items + QUIET_TAIL >= 19 + RAND_ITEMS);
      pick    = (seq_no == 0) ? 12 : $urandom_range(0, 12);
      mkt     = 2'($urandom_range(0, MARKETS - 1));
      sym     = 3'($urandom_range(0, SYMBOLS - 1));
      sd      = 1'($urandom_range(0, 1));
      base    = $urandom;
      if (pick <= 7) begin
        // Well-formed: a few levels around a base price, then orders against them
        nlev = $urandom_range(1, 6);
        for (j = 0; j < nlev; j++)
          send_request(REQ_LOAD, mkt, sym, sd, base + 32'($urandom_range(0, 16)) - 32'd8,
                       pick_qty(), $urandom);
        nlev = $urandom_range(1, 3);
        for (j = 0; j < nlev; j++) begin
          qty = ($urandom_range(0, 3) == 0) ? pick_qty() : 32'($urandom_range(1, 200));
          send_request(REQ_MATCH, mkt, sym, sd, base + 32'($urandom_range(0, 16)) - 32'd8,
                       qty, $urandom);
        end
      end else if (pick == 8) begin
        // Absent book
        send_request(1'($urandom_range(0, 1)), 2'd3, 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), $urandom, pick_qty(), $urandom);
      end else if (pick <= 10) begin
        // Noise: every field at random
        send_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                     3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     $urandom, $urandom, $urandom);
      end else if (pick == 12 && !quiet) begin
        // Fill a book past capacity, then sweep it with one large order
        for (j = 0; j < LEVELS + 2; j++)
          send_request(REQ_LOAD, mkt, sym, sd, $urandom, $urandom_range(1, 50), $urandom);
        send_request(REQ_MATCH, mkt, sym, sd, sd ? 32'd0 : 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, $urandom);
      end else begin
        // Order with a limit that takes every level of the book
        send_request(REQ_MATCH, mkt, sym, sd, sd ? 32'd0 : 32'hFFFF_FFFF, pick_qty(),
                     $urandom);
      end
      seq_no++;
    end
    start <= 1'b0;

    // Drain outstanding reports, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (LEVELS + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("order_book_level_matcher_unit regression: pass");
    else
      $display("order_book_level_matcher_unit regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("order_book_level_matcher_unit regression: fail");
    $finish;
  end
endmodule
